FILE: rtl/core/fstg_pkg.sv
// fstg_pkg: shared widths, register indexes, reset values and the sine
// quarter-wave generator for the faded sine tone generator.
// No dependencies.
package fstg_pkg;

	localparam int PHASE_W    = 32;
	localparam int NOTE_LEN_W = 20;
	localparam int AMP_W      = 15;
	localparam int SMAG_W     = 15;
	localparam int FRAC_W     = 15;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int FADE_LEN_DEF        = 50;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int INDEX_BITS_DEF      = 20;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PHASE_INC = 2'd0;
	localparam cfg_idx_t REG_NOTE_LEN  = 2'd1;
	localparam cfg_idx_t REG_AMPLITUDE = 2'd2;

	localparam logic [PHASE_W-1:0]    PHASE_INC_RST = 32'd118111601;
	localparam logic [NOTE_LEN_W-1:0] NOTE_LEN_RST  = 20'd1600;
	localparam logic [AMP_W-1:0]      AMP_RST       = 15'd8000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// q30 taylor series of sin over the first quarter, rounded to q15
	function automatic logic [SMAG_W-1:0] sine_quarter(input int unsigned k,
			input int unsigned tbits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] sum;
		x    = (64'(k) * HALF_PI_Q30) >> (tbits - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + signed'(term);
		if (sum < 0) begin
			sum = '0;
		end
		v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[SMAG_W-1:0];
	endfunction

endpackage

FILE: rtl/core/fstg_smul.sv
// fstg_smul: shift-add multiplier, one multiplier bit per cycle.
// No package dependencies.
module fstg_smul #(
	parameter int AW = 30,
	parameter int BW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] prod,
	output logic          done
);

	localparam int CW = $clog2(BW + 1);

	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] acc_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [AW:0]      sum;

	assign sum = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : {(AW + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[BW-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

FILE: rtl/core/fstg_sdiv.sv
// fstg_sdiv: restoring divider by a fixed divisor, one quotient bit per cycle.
// No package dependencies.
module fstg_sdiv #(
	parameter int NW      = 30,
	parameter int DIVISOR = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	output logic [NW-1:0] quo,
	output logic          done
);

	localparam int RW = $clog2(DIVISOR + 1) + 1;
	localparam int CW = $clog2(NW + 1);

	logic [RW-1:0] rem_q;
	logic [NW-1:0] sh_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] trial;
	logic          qbit;

	assign trial = {rem_q[RW-2:0], sh_q[NW-1]};
	assign qbit  = (trial >= RW'(DIVISOR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= num;
		end else if (busy_q) begin
			rem_q <= qbit ? (trial - RW'(DIVISOR)) : trial;
			sh_q  <= {sh_q[NW-2:0], qbit};
		end
	end

	assign quo  = sh_q;
	assign done = done_q;

endmodule

FILE: rtl/core/faded_sine_tone_generator_unit.sv
// faded_sine_tone_generator_unit: dds sine tone with linear fade in and out.
// Depends on fstg_pkg, fstg_smul and fstg_sdiv.
//
//   channel  signals                              direction
//   cfg      cfg_we cfg_index cfg_data            write in
//   in       in_valid in_stall start_req          sample tick in
//   out      out_valid out_stall sample last idle sample out
//
// A playing sample runs two 15-step passes of the serial multiplier and a
// 30-step serial divide by the fade length, framed by control states. An idle
// tick skips the multiplier and divider. One tick is in work at a time.
// Reset loads the register defaults and leaves the note ended until a start.
// Ticks are taken while a result waits in the output; a stall there holds S_FIN.
module faded_sine_tone_generator_unit #(
	parameter int FADE_LEN        = fstg_pkg::FADE_LEN_DEF,
	parameter int SINE_TABLE_BITS = fstg_pkg::SINE_TABLE_BITS_DEF,
	parameter int INDEX_BITS      = fstg_pkg::INDEX_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  fstg_pkg::cfg_idx_t                   cfg_index,
	input  logic [fstg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 start_req,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fstg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 last,
	output logic                                 idle
);

	localparam int STB     = SINE_TABLE_BITS;
	localparam int IW      = INDEX_BITS;
	localparam int QUARTER = 1 << (STB - 2);
	localparam int TIW     = STB - 1;
	localparam int QW      = (QUARTER + 1) * fstg_pkg::SMAG_W;
	localparam int WW      = $clog2(FADE_LEN + 1);
	localparam int BW      = (WW > fstg_pkg::SMAG_W) ? WW : fstg_pkg::SMAG_W;
	localparam int MW      = fstg_pkg::AMP_W + fstg_pkg::SMAG_W;
	localparam int PW      = MW + BW;
	localparam int NQ      = PW - fstg_pkg::FRAC_W;
	localparam int LW      = (IW > fstg_pkg::NOTE_LEN_W) ? IW : fstg_pkg::NOTE_LEN_W;
	localparam int EW      = LW + 1;

	function automatic logic [QW-1:0] build_qtab();
		logic [QW-1:0] t;
		t = '0;
		for (int k = 0; k <= QUARTER; k++) begin
			t[k*fstg_pkg::SMAG_W +: fstg_pkg::SMAG_W] =
				fstg_pkg::sine_quarter(int'(k), int'(STB));
		end
		return t;
	endfunction

	localparam logic [QW-1:0] QTAB = build_qtab();

	typedef enum logic [2:0] {
		S_IDLE, S_MUL1, S_WAIT1, S_MUL2, S_WAIT2, S_DIV, S_WAIT3, S_FIN
	} state_t;

	state_t state_q;

	logic [fstg_pkg::PHASE_W-1:0]    phase_inc_q;
	logic [fstg_pkg::NOTE_LEN_W-1:0] note_len_q;
	logic [fstg_pkg::AMP_W-1:0]      amp_q;

	logic [IW-1:0]                   idx_q;
	logic [fstg_pkg::PHASE_W-1:0]    phase_q;
	logic                            done_q;

	logic [WW-1:0]                   w_q;
	logic [fstg_pkg::SMAG_W-1:0]     s_mag_q;
	logic                            s_neg_q;
	logic [fstg_pkg::SAMPLE_W-1:0]   res_sample_q;
	logic                            res_last_q;
	logic                            res_idle_q;

	logic                            out_valid_q;
	logic [fstg_pkg::SAMPLE_W-1:0]   sample_q;
	logic                            last_q;
	logic                            idle_q;

	// next-tick view of the note state
	logic [IW-1:0]                   idx_n;
	logic [fstg_pkg::PHASE_W-1:0]    ph_n;
	logic                            done_n;
	logic [LW-1:0]                   len_x;
	logic [IW-1:0]                   len_eff;
	logic                            play_idle;
	logic [EW-1:0]                   i_x;
	logic [EW-1:0]                   len_e;
	logic [EW-1:0]                   f_x;
	logic [WW-1:0]                   w_n;
	logic                            last_n;
	logic [STB-1:0]                  tp;
	logic [1:0]                      quad;
	logic [STB-3:0]                  r;
	logic [TIW-1:0]                  ti;
	logic [fstg_pkg::SMAG_W-1:0]     s_mag_n;

	logic                            mul_start;
	logic [MW-1:0]                   mul_a;
	logic [BW-1:0]                   mul_b;
	logic [PW-1:0]                   mul_prod;
	logic                            mul_done;
	logic                            div_start;
	logic [NQ-1:0]                   div_quo;
	logic                            div_done;
	logic [fstg_pkg::SAMPLE_W-1:0]   mag16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= fstg_pkg::PHASE_INC_RST;
			note_len_q  <= fstg_pkg::NOTE_LEN_RST;
			amp_q       <= fstg_pkg::AMP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fstg_pkg::REG_PHASE_INC: phase_inc_q <= cfg_data;
				fstg_pkg::REG_NOTE_LEN:  note_len_q <= cfg_data[fstg_pkg::NOTE_LEN_W-1:0];
				fstg_pkg::REG_AMPLITUDE: amp_q <= cfg_data[fstg_pkg::AMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		idx_n     = start_req ? '0 : idx_q;
		ph_n      = start_req ? '0 : phase_q;
		done_n    = start_req ? 1'b0 : done_q;
		len_x     = LW'(note_len_q);
		len_eff   = (len_x > LW'({IW{1'b1}})) ? {IW{1'b1}} : IW'(len_x);
		play_idle = done_n || (idx_n >= len_eff);
		i_x       = EW'(idx_n);
		len_e     = EW'(len_eff);
		f_x       = EW'(FADE_LEN);
		if (i_x < f_x) begin
			w_n = WW'(i_x);
		end else if ((i_x + f_x) > len_e) begin
			w_n = WW'(len_e - i_x);
		end else begin
			w_n = WW'(FADE_LEN);
		end
		last_n  = ((i_x + EW'(1)) == len_e);
		tp      = ph_n[fstg_pkg::PHASE_W-1 -: STB];
		quad    = tp[STB-1 -: 2];
		r       = tp[STB-3:0];
		ti      = quad[0] ? (TIW'(QUARTER) - {1'b0, r}) : {1'b0, r};
		s_mag_n = QTAB[ti*fstg_pkg::SMAG_W +: fstg_pkg::SMAG_W];
	end

	assign mul_start = (state_q == S_MUL1) || (state_q == S_MUL2);
	assign mul_a     = (state_q == S_MUL1) ? MW'(amp_q) : mul_prod[MW-1:0];
	assign mul_b     = (state_q == S_MUL1) ? BW'(s_mag_q) : BW'(w_q);
	assign div_start = (state_q == S_DIV);
	assign mag16     = {1'b0, div_quo[fstg_pkg::SMAG_W-1:0]};

	fstg_smul #(
		.AW (MW),
		.BW (BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	fstg_sdiv #(
		.NW      (NQ),
		.DIVISOR (FADE_LEN)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_prod[PW-1:fstg_pkg::FRAC_W]),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			phase_q      <= '0;
			done_q       <= 1'b1;
			w_q          <= '0;
			s_mag_q      <= '0;
			s_neg_q      <= 1'b0;
			res_sample_q <= '0;
			res_last_q   <= 1'b0;
			res_idle_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			sample_q     <= '0;
			last_q       <= 1'b0;
			idle_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (play_idle) begin
							idx_q        <= idx_n;
							phase_q      <= ph_n;
							done_q       <= 1'b1;
							res_sample_q <= '0;
							res_last_q   <= 1'b0;
							res_idle_q   <= 1'b1;
							state_q      <= S_FIN;
						end else begin
							idx_q      <= idx_n + IW'(1);
							phase_q    <= ph_n + phase_inc_q;
							done_q     <= last_n;
							w_q        <= w_n;
							s_mag_q    <= s_mag_n;
							s_neg_q    <= quad[1];
							res_last_q <= last_n;
							res_idle_q <= 1'b0;
							state_q    <= S_MUL1;
						end
					end
				end
				S_MUL1: state_q <= S_WAIT1;
				S_WAIT1: begin
					if (mul_done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: state_q <= S_WAIT2;
				S_WAIT2: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_WAIT3;
				S_WAIT3: begin
					if (div_done) begin
						res_sample_q <= s_neg_q ? (16'd0 - mag16) : mag16;
						state_q      <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						sample_q    <= res_sample_q;
						last_q      <= res_last_q;
						idle_q      <= res_idle_q;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;
	assign idle      = idle_q;

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WAIT1 || state_q == S_WAIT2))
		else $error("multiplier finished outside a wait state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_WAIT3))
		else $error("divider finished outside its wait state");

	a_ended_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !start_req && done_q) |=> (state_q == S_FIN))
		else $error("tick after note end did not produce an idle result");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("output register loaded outside the finish state");

endmodule
